### sv/sad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sad_pkg: shared constants for the SAD stereo block
// Reset values of the registers, register indexes and default maximum sizes.
// ----------------------------------------------------------------------------
package sad_pkg;
    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int MAX_HEIGHT_DEF    = 1024;
    localparam int MAX_DISPARITY_DEF = 64;
    localparam int MAX_RADIUS_DEF    = 7;

    localparam logic [2:0] REG_RADIUS = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_RANGE  = 3'd3;
    localparam logic [2:0] REG_OFFSET = 3'd4;

    localparam logic [2:0]  RADIUS_RST = 3'd5;
    localparam logic [10:0] WIDTH_RST  = 11'd640;
    localparam logic [10:0] HEIGHT_RST = 11'd480;
    localparam logic [6:0]  RANGE_RST  = 7'd64;
    localparam logic [7:0]  OFFSET_RST = 8'd0;
endpackage
`default_nettype wire

### sv/sad_block_stereo_disparity.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sad_block_stereo_disparity: SAD block-matching stereo disparity
// Pixel pairs enter in raster order on the in channel (in_valid/in_stall).
// Line stores keep the last 2*MAX_RADIUS+1 rows of both images. For an
// interior centre the sequencer walks disparities; for each d one shared
// absolute-difference/accumulate unit visits the (2r+1)^2 window pixels,
// one pixel per cycle from the line-store memories, and one compare keeps
// the least sum (ties to smaller d). A word is taken in the idle state and
// written to the line stores in the check state; a non-interior word then
// returns to idle, an interior one passes run and accumulate for each d
// and the output step. in_stall is high while a word is processed. Results
// leave on the out channel through a result register; while out_stall is
// high the result holds, further words are still taken until the next
// result reaches the output step, where it waits until the register frees.
// Reset returns the raster position to zero and the registers to their
// defaults. Line stores are not cleared. Config writes via
// cfg_we/cfg_addr/cfg_data are taken at any edge.
// ----------------------------------------------------------------------------
module sad_block_stereo_disparity #(
    parameter int MAX_WIDTH     = sad_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = sad_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_DISPARITY = sad_pkg::MAX_DISPARITY_DEF,
    parameter int MAX_RADIUS    = sad_pkg::MAX_RADIUS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [10:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  ref_pixel,
    input  wire logic [7:0]  target_pixel,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [9:0]       disparity_x16,
    output logic [9:0]       out_row,
    output logic [9:0]       out_col,
    output logic             frame_last
);
    localparam int LINES = 2 * MAX_RADIUS + 1;
    localparam int LW    = $clog2(LINES);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = LINES * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = 24;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_ACC   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]  radius_reg;
    logic [10:0] width_reg, height_reg;
    logic [6:0]  range_reg;
    logic [7:0]  offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= sad_pkg::RADIUS_RST;
            width_reg  <= sad_pkg::WIDTH_RST;
            height_reg <= sad_pkg::HEIGHT_RST;
            range_reg  <= sad_pkg::RANGE_RST;
            offset_reg <= sad_pkg::OFFSET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                sad_pkg::REG_RADIUS: radius_reg <= cfg_data[2:0];
                sad_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                sad_pkg::REG_HEIGHT: height_reg <= cfg_data;
                sad_pkg::REG_RANGE:  range_reg  <= cfg_data[6:0];
                sad_pkg::REG_OFFSET: offset_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // effective settings
    logic signed [15:0] r_e, w_e, h_e, nd_e, off_e;
    always_comb
    begin
        r_e   = (32'(radius_reg) > MAX_RADIUS) ? 16'(MAX_RADIUS) : 16'(radius_reg);
        w_e   = (32'(width_reg) > MAX_WIDTH) ? 16'(MAX_WIDTH) : 16'(width_reg);
        if (w_e < 16'sd1) w_e = 16'sd1;
        h_e   = (32'(height_reg) > MAX_HEIGHT) ? 16'(MAX_HEIGHT) : 16'(height_reg);
        if (h_e < 16'sd1) h_e = 16'sd1;
        nd_e  = (32'(range_reg) > MAX_DISPARITY) ? 16'(MAX_DISPARITY) : 16'(range_reg);
        off_e = 16'(offset_reg);
    end

    logic [15:0] row_reg, col_reg;
    logic [LW-1:0] row_line_reg, yy_line_reg, line0_reg;
    logic [7:0]  pix_r_reg, pix_t_reg;
    logic signed [15:0] cy_reg, cx_reg, yy_reg, xx_reg, d_reg;
    logic [SW-1:0] sum_reg, best_sum_reg;
    logic [15:0] best_d_reg;
    logic last_reg;
    logic rd_pend_reg;
    logic [7:0] mem_r_q, mem_t_q;
    logic [9:0] res_d_reg, res_row_reg, res_col_reg;
    logic res_last_reg, res_valid_reg;

    logic [7:0] ref_mem [DEPTH];
    logic [7:0] tgt_mem [DEPTH];

    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] ln,
                                              input logic signed [15:0] x);
        logic [XW-1:0] xc;
        begin
            xc = x[XW-1:0];
            addr_of = AW'(32'(ln) * MAX_WIDTH + 32'(xc));
        end
    endfunction

    // line of the top window row: row line minus 2r, wrapped
    logic [15:0] line_lo;
    logic [LW-1:0] line_start;
    assign line_lo    = 16'(row_line_reg) + 16'(LINES) - 16'(2 * r_e);
    assign line_start = (line_lo >= 16'(LINES)) ? LW'(line_lo - 16'(LINES)) : LW'(line_lo);

    logic accept_in;
    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    logic out_take, res_load;
    assign out_take = out_valid && !out_stall;
    assign res_load = (state_reg == ST_OUT) && (!res_valid_reg || out_take);

    logic signed [15:0] shift;
    assign shift = d_reg + off_e;

    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr_r, rd_addr_t;
    assign wr_en     = (state_reg == ST_CHECK);
    assign wr_addr   = addr_of(row_line_reg, 16'(col_reg));
    assign rd_addr_r = addr_of(yy_line_reg, xx_reg);
    assign rd_addr_t = addr_of(yy_line_reg, xx_reg - shift);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ref_mem[wr_addr] <= pix_r_reg;
            tgt_mem[wr_addr] <= pix_t_reg;
        end
        mem_r_q <= ref_mem[rd_addr_r];
        mem_t_q <= tgt_mem[rd_addr_t];
    end

    logic [7:0] ad;
    assign ad = (mem_r_q > mem_t_q) ? mem_r_q - mem_t_q : mem_t_q - mem_r_q;

    logic win_end;
    assign win_end = (yy_reg == cy_reg + r_e) && (xx_reg == cx_reg + r_e);
    logic interior;
    logic signed [15:0] ccy, ccx;
    assign ccy = 16'(row_reg) - r_e;
    assign ccx = 16'(col_reg) - r_e;
    assign interior = (ccy >= r_e + 16'sd1) && (ccy + r_e + 16'sd1 <= h_e) &&
                      (ccx >= nd_e + off_e + r_e + 16'sd1) && (ccx + r_e + 16'sd1 <= w_e);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept_in) state_next = ST_CHECK;
            ST_CHECK: state_next = !interior ? ST_IDLE :
                                   (nd_e == 16'sd0) ? ST_OUT : ST_RUN;
            ST_RUN:   if (win_end) state_next = ST_ACC;
            ST_ACC:   state_next = (d_reg + 16'sd1 >= nd_e) ? ST_OUT : ST_RUN;
            ST_OUT:   if (res_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic [SW-1:0] sum_fin;
    assign sum_fin = sum_reg + (rd_pend_reg ? SW'(ad) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            row_line_reg  <= '0;
            res_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (out_take)
                res_valid_reg <= 1'b0;
            rd_pend_reg <= (state_reg == ST_RUN);
            case (state_reg)
                ST_IDLE:
                    if (accept_in)
                    begin
                        pix_r_reg <= ref_pixel;
                        pix_t_reg <= target_pixel;
                    end
                ST_CHECK:
                begin
                    last_reg <= (16'(row_reg) + 1 >= h_e) && (16'(col_reg) + 1 >= w_e);
                    cy_reg <= ccy;
                    cx_reg <= ccx;
                    yy_reg <= ccy - r_e;
                    xx_reg <= ccx - r_e;
                    yy_line_reg <= line_start;
                    line0_reg   <= line_start;
                    d_reg  <= '0;
                    sum_reg <= '0;
                    best_sum_reg <= '1;
                    best_d_reg <= '0;
                    if (16'(col_reg) + 1 >= w_e)
                    begin
                        col_reg <= '0;
                        if (16'(row_reg) + 1 >= h_e)
                        begin
                            row_reg      <= '0;
                            row_line_reg <= '0;
                        end
                        else
                        begin
                            row_reg      <= row_reg + 1;
                            row_line_reg <= (row_line_reg == LW'(LINES - 1)) ?
                                            '0 : row_line_reg + 1'b1;
                        end
                    end
                    else
                        col_reg <= col_reg + 1;
                end
                ST_RUN:
                begin
                    sum_reg <= sum_fin;
                    if (xx_reg == cx_reg + r_e)
                    begin
                        xx_reg <= cx_reg - r_e;
                        yy_reg <= yy_reg + 1;
                        yy_line_reg <= (yy_line_reg == LW'(LINES - 1)) ?
                                       '0 : yy_line_reg + 1'b1;
                    end
                    else
                        xx_reg <= xx_reg + 1;
                end
                ST_ACC:
                begin
                    if (sum_fin < best_sum_reg)
                    begin
                        best_sum_reg <= sum_fin;
                        best_d_reg   <= 16'(d_reg);
                    end
                    sum_reg <= '0;
                    d_reg  <= d_reg + 1;
                    yy_reg <= cy_reg - r_e;
                    xx_reg <= cx_reg - r_e;
                    yy_line_reg <= line0_reg;
                end
                ST_OUT:
                    if (res_load)
                    begin
                        res_d_reg     <= 10'(best_d_reg * 16);
                        res_row_reg   <= cy_reg[9:0];
                        res_col_reg   <= cx_reg[9:0];
                        res_last_reg  <= last_reg;
                    end
                default: ;
            endcase
        end
    end

    assign out_valid     = res_valid_reg;
    assign disparity_x16 = res_d_reg;
    assign out_row       = res_row_reg;
    assign out_col       = res_col_reg;
    assign frame_last    = res_last_reg;

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("word taken while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(disparity_x16)))
        else $error("result lost under stall");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> out_valid)
        else $error("result not posted");
endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for sad_block_stereo_disparity
// Feeds whole frames of pixel pairs under several register settings,
// predicts every disparity word with a behavioral model of the window
// search and compares each delivered word field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LINES = 2 * sad_pkg::MAX_RADIUS_DEF + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED = 8;

    typedef enum int {PAT_ZERO, PAT_RAND, PAT_SHIFT, PAT_MAXDIFF} pattern_t;

    typedef struct {
        int       radius;
        int       width;
        int       height;
        int       range;
        int       offset;
        pattern_t pat;
        int       disp_fixed;
    } frame_t;

    typedef struct {
        logic [9:0] disp;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } disp_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [10:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  ref_pixel = '0;
    logic [7:0]  target_pixel = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [9:0]  disparity_x16;
    logic [9:0]  out_row;
    logic [9:0]  out_col;
    logic        frame_last;

    sad_block_stereo_disparity u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .ref_pixel(ref_pixel), .target_pixel(target_pixel),
        .out_valid(out_valid), .out_stall(out_stall),
        .disparity_x16(disparity_x16), .out_row(out_row), .out_col(out_col),
        .frame_last(frame_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic [7:0] ref_lines [LINES][1024];
    logic [7:0] tgt_lines [LINES][1024];
    int pos_row = 0, pos_col = 0;
    logic [2:0]  m_radius = sad_pkg::RADIUS_RST;
    logic [10:0] m_width  = sad_pkg::WIDTH_RST;
    logic [10:0] m_height = sad_pkg::HEIGHT_RST;
    logic [6:0]  m_range  = sad_pkg::RANGE_RST;
    logic [7:0]  m_offset = sad_pkg::OFFSET_RST;
    int disp_fixed = -1;

    disp_word_t expected_words[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    bit hold_req = 0;
    int cycles = 0;

    function automatic int wrap1024(int v);
        return ((v % 1024) + 1024) % 1024;
    endfunction

    function automatic int window_cost(int cy, int cx, int r, int shift);
        int total, yy, xx, a, b;
        total = 0;
        for (yy = cy - r; yy <= cy + r; yy++)
            for (xx = cx - r; xx <= cx + r; xx++)
            begin
                a = ref_lines[yy % LINES][wrap1024(xx)];
                b = tgt_lines[yy % LINES][wrap1024(xx - shift)];
                total += (a > b) ? a - b : b - a;
            end
        return total;
    endfunction

    task automatic predict_disparity(input logic [7:0] a, input logic [7:0] b);
        int r, w, h, nd, off, cy, cx, d, cost, best_cost, best_d;
        disp_word_t e;
        r = m_radius;
        w = (m_width > 1024) ? 1024 : ((m_width < 1) ? 1 : m_width);
        h = (m_height > 1024) ? 1024 : ((m_height < 1) ? 1 : m_height);
        nd = (m_range > 64) ? 64 : m_range;
        off = m_offset;
        ref_lines[pos_row % LINES][pos_col] = a;
        tgt_lines[pos_row % LINES][pos_col] = b;
        cy = pos_row - r;
        cx = pos_col - r;
        if (cy >= r + 1 && cy + r + 1 <= h && cx >= nd + off + r + 1 && cx + r + 1 <= w)
        begin
            best_cost = 32'h7fffffff;
            best_d = 0;
            for (d = 0; d < nd; d++)
            begin
                cost = window_cost(cy, cx, r, d + off);
                if (cost < best_cost)
                begin
                    best_cost = cost;
                    best_d = d;
                end
            end
            e.disp = (disp_fixed >= 0) ? 10'(disp_fixed) : 10'(best_d * 16);
            e.row = 10'(cy);
            e.col = 10'(cx);
            e.last = (pos_row + 1 >= h) && (pos_col + 1 >= w);
            expected_words.push_back(e);
        end
        if (pos_col + 1 >= w)
        begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
        end
        else
            pos_col++;
    endtask

    // result side
    always @(posedge clk)
    begin
        disp_word_t e;
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: row %0d col %0d", out_row, out_col);
                errors++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (disparity_x16 !== e.disp)
                begin
                    $error("disparity_x16: expected %0d actual %0d", e.disp, disparity_x16);
                    errors++;
                end
                if (out_row !== e.row)
                begin
                    $error("out_row: expected %0d actual %0d", e.row, out_row);
                    errors++;
                end
                if (out_col !== e.col)
                begin
                    $error("out_col: expected %0d actual %0d", e.col, out_col);
                    errors++;
                end
                if (frame_last !== e.last)
                begin
                    $error("frame_last: expected %0d actual %0d", e.last, frame_last);
                    errors++;
                end
            end
        end
        if (hold_req)
        begin
            hold_req = 0;
            hold_cycles = 3000;
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[sad_block_stereo_disparity] ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] a, input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ref_pixel <= a;
        target_pixel <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_disparity(a, b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= 11'(value);
        @(posedge clk);
        case (idx)
            sad_pkg::REG_RADIUS: m_radius = 3'(value);
            sad_pkg::REG_WIDTH:  m_width = 11'(value);
            sad_pkg::REG_HEIGHT: m_height = 11'(value);
            sad_pkg::REG_RANGE:  m_range = 7'(value);
            sad_pkg::REG_OFFSET: m_offset = 8'(value);
            default: ;
        endcase
    endtask

    task automatic run_frame(input frame_t f, input int mode, input int pressure);
        int w, h, y, x, k, n, maxd;
        logic [7:0] rrow [1024];
        logic [7:0] trow [1024];
        set_reg(sad_pkg::REG_RADIUS, f.radius);
        set_reg(sad_pkg::REG_WIDTH, f.width);
        set_reg(sad_pkg::REG_HEIGHT, f.height);
        set_reg(sad_pkg::REG_RANGE, f.range);
        set_reg(sad_pkg::REG_OFFSET, f.offset);
        cfg_we <= 1'b0;
        disp_fixed = f.disp_fixed;
        send_idle_pct = (mode == 1) ? 80 : ((mode == 3) ? 14 : 0);
        recv_stall_pct = (mode == 2) ? 80 : ((mode == 3) ? 14 : 0);
        w = (f.width > 1024) ? 1024 : ((f.width < 1) ? 1 : f.width);
        h = (f.height > 1024) ? 1024 : ((f.height < 1) ? 1 : f.height);
        maxd = (f.range > 64) ? 64 : ((f.range < 1) ? 1 : f.range);
        n = 0;
        for (y = 0; y < h; y++)
        begin
            k = $urandom_range(maxd - 1) + f.offset;
            for (x = 0; x < w; x++)
                rrow[x] = 8'($urandom);
            for (x = 0; x < w; x++)
            begin
                case (f.pat)
                    PAT_ZERO:    begin rrow[x] = 8'h00; trow[x] = 8'h00; end
                    PAT_MAXDIFF: begin rrow[x] = 8'hff; trow[x] = 8'h00; end
                    PAT_SHIFT:   trow[x] = (x + k < w && $urandom_range(7) != 0)
                                     ? rrow[x + k] : 8'($urandom);
                    default:     trow[x] = 8'($urandom);
                endcase
            end
            for (x = 0; x < w; x++)
            begin
                send_word(rrow[x], trow[x]);
                n++;
                if (pressure == 1 && n == 10)
                    hold_req = 1;
                if (pressure == 2 && n == 20)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (expected_words.size() != 0) @(posedge clk);
                end
            end
        end
        drain();
    endtask

    frame_t directed [N_DIRECTED] = '{
        '{1, 6,    5,    1,   0,   PAT_ZERO,    0},
        '{1, 0,    5,    1,   0,   PAT_RAND,    -1},
        '{1, 6,    0,    2,   0,   PAT_RAND,    -1},
        '{2, 10,   7,    0,   3,   PAT_RAND,    0},
        '{1, 10,   5,    4,   2,   PAT_SHIFT,   -1},
        '{0, 8,    5,    2,   0,   PAT_SHIFT,   -1},
        '{3, 9,    8,    1,   0,   PAT_MAXDIFF, 0},
        '{1, 8,    4,    1,   255, PAT_RAND,    0}
    };

    initial
    begin
        frame_t f;
        int i, sent;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < N_DIRECTED; i++)
            run_frame(directed[i], i % 4, 0);
        sent = 0;
        i = 0;
        while (sent < 140 || i < 4)
        begin
            f.radius = 1;
            f.range = $urandom_range(3, 1);
            f.offset = $urandom_range(2);
            f.width = f.range + f.offset + 2 * f.radius + 2 + $urandom_range(3);
            f.height = 2 * f.radius + 2 + $urandom_range(2);
            f.pat = ($urandom_range(4) == 0) ? PAT_RAND : PAT_SHIFT;
            f.disp_fixed = -1;
            run_frame(f, i % 4, (i == 0) ? 1 : ((i == 1) ? 2 : 0));
            sent += f.width * f.height;
            i++;
        end
        if (errors == 0)
            $display("[sad_block_stereo_disparity] OK");
        else
            $display("[sad_block_stereo_disparity] ERROR");
        $finish;
    end
endmodule

### sim.f
sv/sad_pkg.sv
sv/sad_block_stereo_disparity.sv
verif/testbench.sv
